### hdl/hnm_pkg.sv
package hnm_pkg;

   // Request operation codes.
   typedef enum logic {
      OP_LOAD  = 1'b0,
      OP_QUERY = 1'b1
   } op_type;

   // Field widths of the channels.
   localparam int COORD_W  = 9;
   localparam int HEIGHT_W = 16;
   localparam int GAIN_W   = 16;
   localparam int BYTE_W   = 8;

   // Internal arithmetic widths.
   localparam int DIFF_W   = HEIGHT_W + 1;          // height difference, Q.14
   localparam int PROD_W   = DIFF_W + GAIN_W + 1;   // difference times gain
   localparam int G_W      = 21;                    // scaled gradient, signed
   localparam int MAG_W    = G_W - 1;               // gradient magnitude
   localparam int SQ_W     = 2 * MAG_W;             // squared gradient
   localparam int SUM_W    = SQ_W + 2;              // squared length, Q.28
   localparam int SQRT_SHIFT = 16;                  // radicand is sum << 16
   localparam int ROOT_W   = (SUM_W + SQRT_SHIFT) / 2;   // length, Q.22
   localparam int SQREM_W  = ROOT_W + 2;
   localparam int RECIP_W  = 31;                    // reciprocal length, Q.30
   localparam int DIVREM_W = ROOT_W + 1;
   localparam int PRD_W    = MAG_W + RECIP_W;
   localparam int T_W      = 32;

   // Constants of the fixed-point format.
   localparam logic [GAIN_W-1:0]   GAIN_RESET = GAIN_W'(4096);
   localparam logic signed [G_W-1:0] G_LIMIT  = G_W'(1048575);
   localparam logic [SUM_W-1:0]    ONE_Q28    = SUM_W'(1) << 28;
   localparam logic [RECIP_W-1:0]  ONE_Q30    = RECIP_W'(1) << 30;
   localparam logic [T_W-1:0]      HALF_T     = T_W'(1) << 30;
   // Partial remainder of 2^52 before the first quotient bit that can be set.
   localparam logic [DIVREM_W-1:0] DIV_START  = DIVREM_W'(1) << 21;

   // Gradient information that travels beside the reciprocal square root.
   typedef struct packed {
      logic [MAG_W-1:0] mag_x;
      logic [MAG_W-1:0] mag_y;
      logic             flip_x;
      logic             flip_y;
   } side_type;

endpackage

### hdl/hnm_rsqrt.sv
module hnm_rsqrt (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          en,
   input  logic                          in_valid,
   input  logic [hnm_pkg::SUM_W-1:0]     in_sum,
   input  hnm_pkg::side_type             in_side,
   output logic                          out_valid,
   output logic [hnm_pkg::RECIP_W-1:0]   out_recip,
   output hnm_pkg::side_type             out_side
);
   import hnm_pkg::*;

   // Square root stages: one result bit per stage.
   logic                sv_ff    [ROOT_W];
   logic [SUM_W-1:0]    ss_ff    [ROOT_W];
   logic [ROOT_W-1:0]   sr_ff    [ROOT_W];
   logic [SQREM_W-1:0]  sm_ff    [ROOT_W];
   side_type            sside_ff [ROOT_W];

   // Reciprocal stages: one quotient bit per stage.
   logic                dv_ff    [RECIP_W];
   logic [ROOT_W-1:0]   dl_ff    [RECIP_W];
   logic [DIVREM_W-1:0] dm_ff    [RECIP_W];
   logic [RECIP_W-1:0]  dq_ff    [RECIP_W];
   side_type            dside_ff [RECIP_W];

   // Digit-by-digit square root of (sum << 16), two radicand bits a stage.
   for (genvar k = 0; k < ROOT_W; k++) begin : g_sqrt
      localparam int P = ROOT_W - 1 - k;
      logic                pv;
      logic [SUM_W-1:0]    ps;
      logic [ROOT_W-1:0]   pr;
      logic [SQREM_W-1:0]  pm;
      side_type            pside;
      logic [1:0]          pair;
      logic [SQREM_W-1:0]  rem_sh;
      logic [SQREM_W-1:0]  trial;

      if (k == 0) begin : g_first
         assign pv    = in_valid;
         assign ps    = in_sum;
         assign pr    = '0;
         assign pm    = '0;
         assign pside = in_side;
      end else begin : g_next
         assign pv    = sv_ff[k-1];
         assign ps    = ss_ff[k-1];
         assign pr    = sr_ff[k-1];
         assign pm    = sm_ff[k-1];
         assign pside = sside_ff[k-1];
      end

      // The low radicand pairs come from the shift and are zero.
      if (2 * P >= SQRT_SHIFT) begin : g_bits
         assign pair = ps[2*P+1-SQRT_SHIFT -: 2];
      end else begin : g_zero
         assign pair = 2'b00;
      end

      assign rem_sh = {pm[SQREM_W-3:0], pair};
      assign trial  = {pr, 2'b01};

      always_ff @(posedge clock) begin
         if (reset) begin
            sv_ff[k] <= 1'b0;
         end else if (en) begin
            sv_ff[k] <= pv;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            ss_ff[k]    <= ps;
            sside_ff[k] <= pside;
            if (rem_sh >= trial) begin
               sm_ff[k] <= rem_sh - trial;
               sr_ff[k] <= {pr[ROOT_W-2:0], 1'b1};
            end else begin
               sm_ff[k] <= rem_sh;
               sr_ff[k] <= {pr[ROOT_W-2:0], 1'b0};
            end
         end
      end
   end

   // Restoring division of 2^52 by the length. The length is at least 2^22,
   // so only the low quotient bits can be set.
   for (genvar j = 0; j < RECIP_W; j++) begin : g_div
      logic                pv;
      logic [ROOT_W-1:0]   pl;
      logic [DIVREM_W-1:0] pm;
      logic [RECIP_W-1:0]  pq;
      side_type            pside;
      logic [DIVREM_W-1:0] rem_sh;
      logic [DIVREM_W-1:0] divisor;

      if (j == 0) begin : g_first
         assign pv    = sv_ff[ROOT_W-1];
         assign pl    = sr_ff[ROOT_W-1];
         assign pm    = DIV_START;
         assign pq    = '0;
         assign pside = sside_ff[ROOT_W-1];
      end else begin : g_next
         assign pv    = dv_ff[j-1];
         assign pl    = dl_ff[j-1];
         assign pm    = dm_ff[j-1];
         assign pq    = dq_ff[j-1];
         assign pside = dside_ff[j-1];
      end

      assign rem_sh  = {pm[DIVREM_W-2:0], 1'b0};
      assign divisor = {1'b0, pl};

      always_ff @(posedge clock) begin
         if (reset) begin
            dv_ff[j] <= 1'b0;
         end else if (en) begin
            dv_ff[j] <= pv;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            dl_ff[j]    <= pl;
            dside_ff[j] <= pside;
            if (rem_sh >= divisor) begin
               dm_ff[j] <= rem_sh - divisor;
               dq_ff[j] <= {pq[RECIP_W-2:0], 1'b1};
            end else begin
               dm_ff[j] <= rem_sh;
               dq_ff[j] <= {pq[RECIP_W-2:0], 1'b0};
            end
         end
      end
   end

   assign out_valid = dv_ff[RECIP_W-1];
   assign out_recip = dq_ff[RECIP_W-1];
   assign out_side  = dside_ff[RECIP_W-1];

endmodule

### hdl/height_to_normal_map.sv
// Channel   Direction  Handshake              Payload
// req       in         req_valid/req_ready    operation, col_x, row_y, height_sample
// rsp       out        rsp_valid/rsp_ready    normal_red, normal_green, normal_blue
// csr       in         csr_valid/csr_ready    strength_gain
//
// One request enters per cycle while req_ready is high, loads and queries alike;
// the height store is kept in two identical banks with two read ports each, so all
// four neighbors of a query are read in the same cycle. Reset clears the valid bits
// and sets the gain to 1.0; the store is not cleared. A stalled result moves
// the next one into a skid register; only when that is full does req_ready drop and
// the whole pipeline hold.
module height_to_normal_map #(
   parameter int SIDE = 512
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic                         req_operation,
   input  logic [hnm_pkg::COORD_W-1:0]  req_col_x,
   input  logic [hnm_pkg::COORD_W-1:0]  req_row_y,
   input  logic signed [hnm_pkg::HEIGHT_W-1:0] req_height_sample,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [hnm_pkg::BYTE_W-1:0]   rsp_normal_red,
   output logic [hnm_pkg::BYTE_W-1:0]   rsp_normal_green,
   output logic [hnm_pkg::BYTE_W-1:0]   rsp_normal_blue,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [hnm_pkg::GAIN_W-1:0]   csr_strength_gain
);
   import hnm_pkg::*;

   localparam int CW    = $clog2(SIDE);
   localparam int DEPTH = SIDE * SIDE;
   localparam int AW    = $clog2(DEPTH);
   localparam int RECIP_SHIFT = 20;
   localparam int QP_W  = COORD_W + RECIP_SHIFT;
   localparam logic [QP_W-1:0] MOD_RECIP = QP_W'((2 ** RECIP_SHIFT) / SIDE);
   localparam logic [CW-1:0]   LAST_COORD = CW'(SIDE - 1);
   localparam logic [AW-1:0]   SIDE_A = AW'(SIDE);

   // Pipeline moves whenever the skid register is free.
   logic en;

   logic [GAIN_W-1:0] gain_ff;

   // Stage 0: coordinate quotients by SIDE.
   logic                v0_ff;
   op_type              op0_ff;
   logic [HEIGHT_W-1:0] h0_ff;
   logic [COORD_W-1:0]  xr0_ff, yr0_ff, xq0_ff, yq0_ff;
   logic [QP_W-1:0]     xprod, yprod;

   // Stage 1: wrapped coordinates.
   logic                v1_ff;
   op_type              op1_ff;
   logic [HEIGHT_W-1:0] h1_ff;
   logic [CW-1:0]       x1_ff, y1_ff;

   // Stage 2: neighbor coordinates.
   logic                v2_ff;
   op_type              op2_ff;
   logic [HEIGHT_W-1:0] h2_ff;
   logic [CW-1:0]       x2_ff, y2_ff, xm2_ff, xp2_ff, ym2_ff, yp2_ff;

   // Stage 3: store addresses.
   logic                v3_ff;
   op_type              op3_ff;
   logic [HEIGHT_W-1:0] h3_ff;
   logic [AW-1:0]       aw3_ff, axm3_ff, axp3_ff, aym3_ff, ayp3_ff;

   // Stage 4: store read data, queries only from here on.
   logic                v4_ff;
   logic [HEIGHT_W-1:0] row_mem [DEPTH];
   logic [HEIGHT_W-1:0] col_mem [DEPTH];
   logic [HEIGHT_W-1:0] hxm4_ff, hxp4_ff, hym4_ff, hyp4_ff;

   // Stages 5 to 9: gradients and squared length.
   logic                     v5_ff, v6_ff, v7_ff, v8_ff, v9_ff;
   logic signed [DIFF_W-1:0] dx5_ff, dy5_ff;
   logic signed [PROD_W-1:0] px6_ff, py6_ff;
   logic signed [G_W-1:0]    gx7_ff, gy7_ff;
   logic signed [2*G_W-1:0]  sqx_full, sqy_full;
   logic [SQ_W-1:0]          sqx8_ff, sqy8_ff;
   side_type                 side8_ff, side9_ff;
   logic [SUM_W-1:0]         sum9_ff;

   // Reciprocal length unit.
   logic               rs_valid;
   logic [RECIP_W-1:0] rs_recip;
   side_type           rs_side;

   // Stages A and B: components and their offsets.
   logic               va_ff, vb_ff;
   logic [PRD_W-1:0]   prx_a_ff, pry_a_ff;
   logic [RECIP_W-1:0] r_a_ff;
   logic               flx_a_ff, fly_a_ff;
   logic [T_W-1:0]     tx_b_ff, ty_b_ff, tz_b_ff;

   // Output register and skid register.
   logic                rsp_valid_ff, skid_valid_ff;
   logic [BYTE_W-1:0]   red_ff, green_ff, blue_ff;
   logic [BYTE_W-1:0]   skid_red_ff, skid_green_ff, skid_blue_ff;
   logic [BYTE_W-1:0]   tail_red, tail_green, tail_blue;

   // Remainder from a quotient that is exact or one too small.
   function automatic logic [CW-1:0] wrap_coord(input logic [COORD_W-1:0] raw,
                                                input logic [COORD_W-1:0] quo);
      logic [COORD_W-1:0] rem;
      rem = raw - COORD_W'(quo * SIDE);
      if (int'(rem) >= SIDE) begin
         rem = rem - COORD_W'(SIDE);
      end
      return CW'(rem);
   endfunction

   // Scale by 1/4096 truncating toward zero, then saturate.
   function automatic logic signed [G_W-1:0] scale_grad(
      input logic signed [PROD_W-1:0] p);
      logic signed [PROD_W-1:0]    adj;
      logic signed [PROD_W-13:0]   q;
      adj = p + $signed({{(PROD_W-12){1'b0}}, {12{p[PROD_W-1]}}});
      q   = adj[PROD_W-1:12];
      if (q > (PROD_W-12)'(G_LIMIT)) begin
         return G_LIMIT;
      end else if (q < -(PROD_W-12)'(G_LIMIT)) begin
         return -G_LIMIT;
      end
      return G_W'(q);
   endfunction

   // Component in Q.30, clamped to one and moved to [0, 2^31].
   function automatic logic [T_W-1:0] offset_comp(input logic [PRD_W-1:14] nm_in,
                                                  input logic flip);
      logic [T_W-1:0] nm;
      if (nm_in > (PRD_W-14)'(ONE_Q30)) begin
         nm = T_W'(ONE_Q30);
      end else begin
         nm = T_W'(nm_in);
      end
      return flip ? (HALF_T - nm) : (HALF_T + nm);
   endfunction

   // Byte of floor(t * 255 / 2^31), clamped to 255.
   function automatic logic [BYTE_W-1:0] to_byte(input logic [T_W-1:0] t);
      logic [T_W+BYTE_W-1:0] scaled;
      logic [BYTE_W:0]       hi;
      scaled = {t, BYTE_W'(0)} - {BYTE_W'(0), t};
      hi     = scaled[T_W+BYTE_W-1:T_W-1];
      return hi[BYTE_W] ? {BYTE_W{1'b1}} : hi[BYTE_W-1:0];
   endfunction

   assign en        = !skid_valid_ff;
   assign req_ready = en;
   assign csr_ready = 1'b1;

   // Gain register.
   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff <= GAIN_RESET;
      end else if (csr_valid) begin
         gain_ff <= csr_strength_gain;
      end
   end

   // Valid bits of the stages outside the reciprocal unit; loads end at the store.
   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
         v7_ff <= 1'b0;
         v8_ff <= 1'b0;
         v9_ff <= 1'b0;
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
      end else if (en) begin
         v0_ff <= req_valid;
         v1_ff <= v0_ff;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff && (op3_ff == OP_QUERY);
         v5_ff <= v4_ff;
         v6_ff <= v5_ff;
         v7_ff <= v6_ff;
         v8_ff <= v7_ff;
         v9_ff <= v8_ff;
         va_ff <= rs_valid;
         vb_ff <= va_ff;
      end
   end

   // Quotient by SIDE through a reciprocal multiply.
   assign xprod = {RECIP_SHIFT'(0), req_col_x} * MOD_RECIP;
   assign yprod = {RECIP_SHIFT'(0), req_row_y} * MOD_RECIP;

   // Front stages: wrap, neighbors and addresses.
   always_ff @(posedge clock) begin
      if (en) begin
         op0_ff <= op_type'(req_operation);
         h0_ff  <= req_height_sample;
         xr0_ff <= req_col_x;
         yr0_ff <= req_row_y;
         xq0_ff <= xprod[QP_W-1:RECIP_SHIFT];
         yq0_ff <= yprod[QP_W-1:RECIP_SHIFT];

         op1_ff <= op0_ff;
         h1_ff  <= h0_ff;
         x1_ff  <= wrap_coord(xr0_ff, xq0_ff);
         y1_ff  <= wrap_coord(yr0_ff, yq0_ff);

         op2_ff <= op1_ff;
         h2_ff  <= h1_ff;
         x2_ff  <= x1_ff;
         y2_ff  <= y1_ff;
         xm2_ff <= (x1_ff == '0) ? LAST_COORD : x1_ff - CW'(1);
         xp2_ff <= (x1_ff == LAST_COORD) ? '0 : x1_ff + CW'(1);
         ym2_ff <= (y1_ff == '0) ? LAST_COORD : y1_ff - CW'(1);
         yp2_ff <= (y1_ff == LAST_COORD) ? '0 : y1_ff + CW'(1);

         op3_ff  <= op2_ff;
         h3_ff   <= h2_ff;
         aw3_ff  <= AW'(y2_ff) * SIDE_A + AW'(x2_ff);
         axm3_ff <= AW'(y2_ff) * SIDE_A + AW'(xm2_ff);
         axp3_ff <= AW'(y2_ff) * SIDE_A + AW'(xp2_ff);
         aym3_ff <= AW'(ym2_ff) * SIDE_A + AW'(x2_ff);
         ayp3_ff <= AW'(yp2_ff) * SIDE_A + AW'(x2_ff);
      end
   end

   // Row bank: serves the horizontal neighbors.
   always_ff @(posedge clock) begin
      if (en) begin
         if (v3_ff && (op3_ff == OP_LOAD)) begin
            row_mem[aw3_ff] <= h3_ff;
         end
         hxm4_ff <= row_mem[axm3_ff];
         hxp4_ff <= row_mem[axp3_ff];
      end
   end

   // Column bank: same contents, serves the vertical neighbors.
   always_ff @(posedge clock) begin
      if (en) begin
         if (v3_ff && (op3_ff == OP_LOAD)) begin
            col_mem[aw3_ff] <= h3_ff;
         end
         hym4_ff <= col_mem[aym3_ff];
         hyp4_ff <= col_mem[ayp3_ff];
      end
   end

   assign sqx_full = gx7_ff * gx7_ff;
   assign sqy_full = gy7_ff * gy7_ff;

   // Differences, gain, scaling, squares and their sum.
   always_ff @(posedge clock) begin
      if (en) begin
         dx5_ff <= DIFF_W'($signed(hxp4_ff)) - DIFF_W'($signed(hxm4_ff));
         dy5_ff <= DIFF_W'($signed(hyp4_ff)) - DIFF_W'($signed(hym4_ff));

         px6_ff <= PROD_W'(dx5_ff) * $signed({2'b00, gain_ff});
         py6_ff <= PROD_W'(dy5_ff) * $signed({2'b00, gain_ff});

         gx7_ff <= scale_grad(px6_ff);
         gy7_ff <= scale_grad(py6_ff);

         sqx8_ff         <= sqx_full[SQ_W-1:0];
         sqy8_ff         <= sqy_full[SQ_W-1:0];
         side8_ff.mag_x  <= gx7_ff[G_W-1] ? MAG_W'(-gx7_ff) : MAG_W'(gx7_ff);
         side8_ff.mag_y  <= gy7_ff[G_W-1] ? MAG_W'(-gy7_ff) : MAG_W'(gy7_ff);
         side8_ff.flip_x <= (gx7_ff > 0);
         side8_ff.flip_y <= (gy7_ff > 0);

         sum9_ff  <= SUM_W'(sqx8_ff) + SUM_W'(sqy8_ff) + ONE_Q28;
         side9_ff <= side8_ff;
      end
   end

   hnm_rsqrt u_rsqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (v9_ff),
      .in_sum    (sum9_ff),
      .in_side   (side9_ff),
      .out_valid (rs_valid),
      .out_recip (rs_recip),
      .out_side  (rs_side)
   );

   // Component products and their byte offsets.
   always_ff @(posedge clock) begin
      if (en) begin
         prx_a_ff <= PRD_W'(rs_side.mag_x) * PRD_W'(rs_recip);
         pry_a_ff <= PRD_W'(rs_side.mag_y) * PRD_W'(rs_recip);
         r_a_ff   <= rs_recip;
         flx_a_ff <= rs_side.flip_x;
         fly_a_ff <= rs_side.flip_y;

         tx_b_ff <= offset_comp(prx_a_ff[PRD_W-1:14], flx_a_ff);
         ty_b_ff <= offset_comp(pry_a_ff[PRD_W-1:14], fly_a_ff);
         tz_b_ff <= offset_comp((PRD_W-14)'(r_a_ff), 1'b0);
      end
   end

   assign tail_red   = to_byte(tx_b_ff);
   assign tail_green = to_byte(ty_b_ff);
   assign tail_blue  = to_byte(tz_b_ff);

   // Output register with a skid register behind it.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (rsp_valid_ff && !rsp_ready) begin
         if (en && vb_ff) begin
            skid_valid_ff <= 1'b1;
         end
      end else begin
         if (skid_valid_ff) begin
            rsp_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            rsp_valid_ff <= en && vb_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_valid_ff && !rsp_ready) begin
         if (en && vb_ff) begin
            skid_red_ff   <= tail_red;
            skid_green_ff <= tail_green;
            skid_blue_ff  <= tail_blue;
         end
      end else if (skid_valid_ff) begin
         red_ff   <= skid_red_ff;
         green_ff <= skid_green_ff;
         blue_ff  <= skid_blue_ff;
      end else if (en && vb_ff) begin
         red_ff   <= tail_red;
         green_ff <= tail_green;
         blue_ff  <= tail_blue;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_normal_red   = red_ff;
   assign rsp_normal_green = green_ff;
   assign rsp_normal_blue  = blue_ff;

   // The skid register only fills behind a waiting result.
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> rsp_valid_ff)
      else $error("skid register holds a result while the output is empty");

   // A taken result is replaced by the skid content.
   a_skid_drains: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ready && skid_valid_ff) |=> (rsp_valid_ff && !skid_valid_ff))
      else $error("skid register did not move to the output");

   // Loads never travel past the store.
   a_load_ends: assert property (@(posedge clock) disable iff (reset)
      (en && v3_ff && (op3_ff == OP_LOAD)) |=> !v4_ff)
      else $error("load request went past the store");

   // Wrapped coordinates lie inside the map.
   a_wrap_range: assert property (@(posedge clock) disable iff (reset)
      v1_ff |-> ((int'(x1_ff) < SIDE) && (int'(y1_ff) < SIDE)))
      else $error("wrapped coordinate outside the map");

   // The reciprocal length never exceeds one.
   a_recip_bound: assert property (@(posedge clock) disable iff (reset)
      rs_valid |-> (rs_recip <= ONE_Q30))
      else $error("reciprocal length above one");

endmodule

### tb/height_to_normal_map_test.sv
`timescale 1ns / 1ps

module height_to_normal_map_test;
   import hnm_pkg::*;

   localparam int SIDE = 512;
   localparam int SETTLE_CYCLES = 80;
   localparam int PHASE_ITEMS = 217;
   localparam longint unsigned ONE_Q30 = 64'd1 << 30;
   localparam longint signed SLOPE_LIMIT = 64'sd1048575;
   localparam logic signed [HEIGHT_W-1:0] H_MIN = 16'sh8000;
   localparam logic signed [HEIGHT_W-1:0] H_MAX = 16'sh7FFF;
   localparam logic signed [HEIGHT_W-1:0] H_MID = 16'sh0ABC;

   typedef struct packed {
      logic [BYTE_W-1:0] red;
      logic [BYTE_W-1:0] green;
      logic [BYTE_W-1:0] blue;
   } normal_type;

   // One row of the directed stimulus; want is used only where fixed is set.
   typedef struct packed {
      op_type                     op;
      logic [COORD_W-1:0]         col;
      logic [COORD_W-1:0]         row;
      logic signed [HEIGHT_W-1:0] height;
      logic                       fixed;
      normal_type                 want;
   } step_row;

   localparam normal_type LEVEL_NORMAL = '{8'd127, 8'd127, 8'd255};
   localparam normal_type NO_NORMAL = '0;

   // Queries at corners of the map, so each has neighbors that wrap around an edge.
   localparam step_row DIRECTED_STEPS [21] = '{
      '{OP_LOAD,  9'd1,   9'd0,   16'sd0, 1'b0, NO_NORMAL},
      '{OP_LOAD,  9'd511, 9'd0,   16'sd0, 1'b0, NO_NORMAL},
      '{OP_LOAD,  9'd0,   9'd1,   16'sd0, 1'b0, NO_NORMAL},
      '{OP_LOAD,  9'd0,   9'd511, 16'sd0, 1'b0, NO_NORMAL},
      '{OP_QUERY, 9'd0,   9'd0,   16'sd0, 1'b1, LEVEL_NORMAL},
      '{OP_LOAD,  9'd1,   9'd0,   H_MIN,  1'b0, NO_NORMAL},
      '{OP_LOAD,  9'd511, 9'd0,   H_MAX,  1'b0, NO_NORMAL},
      '{OP_LOAD,  9'd0,   9'd1,   H_MAX,  1'b0, NO_NORMAL},
      '{OP_LOAD,  9'd0,   9'd511, H_MIN,  1'b0, NO_NORMAL},
      '{OP_QUERY, 9'd0,   9'd0,   16'sd0, 1'b0, NO_NORMAL},
      '{OP_LOAD,  9'd510, 9'd511, 16'sh4000, 1'b0, NO_NORMAL},
      '{OP_LOAD,  9'd511, 9'd510, H_MAX,  1'b0, NO_NORMAL},
      '{OP_QUERY, 9'd511, 9'd511, 16'sd0, 1'b0, NO_NORMAL},
      '{OP_LOAD,  9'd1,   9'd0,   H_MID,  1'b0, NO_NORMAL},
      '{OP_LOAD,  9'd511, 9'd0,   H_MID,  1'b0, NO_NORMAL},
      '{OP_LOAD,  9'd0,   9'd1,   H_MID,  1'b0, NO_NORMAL},
      '{OP_LOAD,  9'd0,   9'd511, H_MID,  1'b0, NO_NORMAL},
      '{OP_QUERY, 9'd0,   9'd0,   16'sd0, 1'b1, LEVEL_NORMAL},
      '{OP_QUERY, 9'd511, 9'd511, 16'sd0, 1'b0, NO_NORMAL},
      '{OP_LOAD,  9'd0,   9'd0,   H_MIN,  1'b0, NO_NORMAL},
      '{OP_QUERY, 9'd0,   9'd0,   16'sd0, 1'b1, LEVEL_NORMAL}
   };

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic req_operation = 1'b0;
   logic [COORD_W-1:0] req_col_x = '0;
   logic [COORD_W-1:0] req_row_y = '0;
   logic signed [HEIGHT_W-1:0] req_height_sample = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [BYTE_W-1:0] rsp_normal_red;
   logic [BYTE_W-1:0] rsp_normal_green;
   logic [BYTE_W-1:0] rsp_normal_blue;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [GAIN_W-1:0] csr_strength_gain = '0;

   // Shadow of the block: height store, which entries hold data, and the gain.
   logic signed [HEIGHT_W-1:0] height_mem [0:SIDE*SIDE-1];
   bit height_loaded [0:SIDE*SIDE-1];
   logic [GAIN_W-1:0] strength_setting = GAIN_RESET;

   normal_type pending_normals [$];
   int unsigned known_centers [$];
   int mismatch_count = 0;
   int req_idle_pct = 27;
   int rsp_idle_pct = 63;

   height_to_normal_map #(.SIDE(SIDE)) u_top (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_operation     (req_operation),
      .req_col_x         (req_col_x),
      .req_row_y         (req_row_y),
      .req_height_sample (req_height_sample),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_normal_red    (rsp_normal_red),
      .rsp_normal_green  (rsp_normal_green),
      .rsp_normal_blue   (rsp_normal_blue),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_strength_gain (csr_strength_gain)
   );

   always #2 clock = ~clock;

   // Hard stop in case the block hangs.
   initial begin
      #2000000;
      $display("Verification failed");
      $finish;
   end

   function automatic longint signed height_at(int unsigned x, int unsigned y);
      longint signed h;
      h = height_mem[y * SIDE + x];
      return h;
   endfunction

   // Height difference times the Q4.12 gain, truncated toward zero and saturated.
   function automatic longint signed scaled_slope(longint signed diff);
      longint signed gain_q12;
      longint signed slope;
      gain_q12 = strength_setting;
      slope = (diff * gain_q12) / 4096;
      if (slope > SLOPE_LIMIT) slope = SLOPE_LIMIT;
      if (slope < -SLOPE_LIMIT) slope = -SLOPE_LIMIT;
      return slope;
   endfunction

   // Integer square root, rounded down, one result bit per pass.
   function automatic longint unsigned root_floor(longint unsigned value);
      longint unsigned rest;
      longint unsigned root;
      longint unsigned probe;
      rest = value;
      root = 0;
      probe = 64'd1 << 62;
      while (probe > rest) probe = probe >> 2;
      while (probe != 0) begin
         if (rest >= root + probe) begin
            rest = rest - (root + probe);
            root = (root >> 1) + probe;
         end else begin
            root = root >> 1;
         end
         probe = probe >> 2;
      end
      return root;
   endfunction

   // Scales one component by the reciprocal length and maps [-1,1] to a byte.
   function automatic logic [BYTE_W-1:0] component_byte(longint signed comp,
                                                        longint unsigned recip);
      longint unsigned mag;
      longint unsigned unit;
      longint signed signed_unit;
      longint unsigned level;
      mag = (comp < 0) ? -comp : comp;
      unit = (mag * recip) >> 14;
      if (unit > ONE_Q30) unit = ONE_Q30;
      signed_unit = (comp < 0) ? -$signed(unit) : $signed(unit);
      level = $unsigned(signed_unit + $signed(ONE_Q30));
      level = (level * 255) >> 31;
      if (level > 255) level = 255;
      return level[BYTE_W-1:0];
   endfunction

   // Normal at (x, y) from the central differences of its wrapped neighbors.
   function automatic normal_type predict_normal(int unsigned x, int unsigned y);
      int unsigned xm;
      int unsigned xp;
      int unsigned ym;
      int unsigned yp;
      longint signed gx;
      longint signed gy;
      longint unsigned length_sq;
      longint unsigned length_q22;
      longint unsigned recip;
      normal_type normal;
      xm = (x + SIDE - 1) % SIDE;
      xp = (x + 1) % SIDE;
      ym = (y + SIDE - 1) % SIDE;
      yp = (y + 1) % SIDE;
      gx = scaled_slope(height_at(xp, y) - height_at(xm, y));
      gy = scaled_slope(height_at(x, yp) - height_at(x, ym));
      length_sq = gx * gx + gy * gy + (64'sd1 << 28);
      length_q22 = root_floor(length_sq << 16);
      if (length_q22 == 0) length_q22 = 1;
      recip = (64'd1 << 52) / length_q22;
      normal.red = component_byte(-gx, recip);
      normal.green = component_byte(-gy, recip);
      normal.blue = component_byte(64'sd16384, recip);
      return normal;
   endfunction

   function automatic bit neighbors_loaded(int unsigned x, int unsigned y);
      return height_loaded[y * SIDE + (x + 1) % SIDE]
         && height_loaded[y * SIDE + (x + SIDE - 1) % SIDE]
         && height_loaded[((y + 1) % SIDE) * SIDE + x]
         && height_loaded[((y + SIDE - 1) % SIDE) * SIDE + x];
   endfunction

   function automatic logic signed [HEIGHT_W-1:0] random_height();
      int unsigned pick;
      pick = $urandom_range(0, 9);
      case (pick)
         0: return H_MIN;
         1: return H_MAX;
         2: return '0;
         default: return $urandom();
      endcase
   endfunction

   // Centers near the origin exercise wrap-around; the rest are anywhere.
   function automatic int unsigned random_coord();
      if ($urandom_range(0, 1) == 1) begin
         return ($urandom_range(0, 15) + SIDE - 8) % SIDE;
      end
      return $urandom_range(0, SIDE - 1);
   endfunction

   // Presents one request and returns at the edge where it is accepted,
   // then updates the shadow store or queues the expected normal.
   task automatic send_request(op_type op, int unsigned x, int unsigned y,
                               logic signed [HEIGHT_W-1:0] height, bit fixed,
                               normal_type want);
      while ($urandom_range(0, 99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_operation <= op;
      req_col_x <= x[COORD_W-1:0];
      req_row_y <= y[COORD_W-1:0];
      req_height_sample <= height;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (op == OP_LOAD) begin
         height_mem[y * SIDE + x] = height;
         height_loaded[y * SIDE + x] = 1'b1;
      end else begin
         pending_normals.push_back(fixed ? want : predict_normal(x, y));
      end
   endtask

   // Holds off new requests until every queued normal has come back and any
   // loads still in flight have drained.
   task automatic drain_block();
      req_valid <= 1'b0;
      while (pending_normals.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_gain(logic [GAIN_W-1:0] gain);
      csr_valid <= 1'b1;
      csr_strength_gain <= gain;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      strength_setting = gain;
   endtask

   // Random traffic: mostly neighbor loads followed by a query of their center,
   // plus repeat queries, abandoned sequences, stray loads and stray queries.
   task automatic run_random(int budget);
      int sent;
      int unsigned pick;
      int unsigned cx;
      int unsigned cy;
      int unsigned nx [4];
      int unsigned ny [4];
      int unsigned spot;
      sent = 0;
      while (sent < budget) begin
         pick = $urandom_range(0, 99);
         if (pick < 70) begin
            cx = random_coord();
            cy = random_coord();
            nx = '{(cx + 1) % SIDE, (cx + SIDE - 1) % SIDE, cx, cx};
            ny = '{cy, cy, (cy + 1) % SIDE, (cy + SIDE - 1) % SIDE};
            for (int k = 0; k < 4; k++) begin
               if (!height_loaded[ny[k] * SIDE + nx[k]] || $urandom_range(0, 1) == 1) begin
                  send_request(OP_LOAD, nx[k], ny[k], random_height(), 1'b0, NO_NORMAL);
                  sent++;
               end
            end
            // Now and then the sequence is abandoned before its query.
            if ($urandom_range(0, 9) != 0) begin
               send_request(OP_QUERY, cx, cy, random_height(), 1'b0, NO_NORMAL);
               sent++;
               known_centers.push_back(cy * SIDE + cx);
               if (known_centers.size() > 64) void'(known_centers.pop_front());
            end
         end else if (pick < 85 && known_centers.size() != 0) begin
            spot = known_centers[$urandom_range(0, known_centers.size() - 1)];
            send_request(OP_QUERY, spot % SIDE, spot / SIDE, random_height(), 1'b0,
                         NO_NORMAL);
            sent++;
         end else begin
            cx = $urandom_range(0, SIDE - 1);
            cy = $urandom_range(0, SIDE - 1);
            if ($urandom_range(0, 3) == 0 && neighbors_loaded(cx, cy)) begin
               send_request(OP_QUERY, cx, cy, random_height(), 1'b0, NO_NORMAL);
            end else begin
               send_request(OP_LOAD, cx, cy, random_height(), 1'b0, NO_NORMAL);
            end
            sent++;
         end
      end
   endtask

   // Result side: compare each accepted normal with the oldest expectation,
   // then decide whether to stall on the next cycle.
   always @(posedge clock) begin : rsp_check
      normal_type want;
      normal_type got;
      got = '{rsp_normal_red, rsp_normal_green, rsp_normal_blue};
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_normals.size() == 0) begin
            mismatch_count++;
            $display("%0t: normal %0d/%0d/%0d arrived with none expected",
                     $time, got.red, got.green, got.blue);
         end else begin
            want = pending_normals.pop_front();
            if (got.red !== want.red || got.green !== want.green
                || got.blue !== want.blue) begin
               mismatch_count++;
               $display("%0t: normal mismatch, expected r/g/b %0d/%0d/%0d, got %0d/%0d/%0d",
                        $time, want.red, want.green, want.blue,
                        got.red, got.green, got.blue);
            end
         end
      end
      rsp_ready <= ($urandom_range(0, 99) >= rsp_idle_pct);
   end

   // Stimulus sequence.
   initial begin : stimulus
      logic [GAIN_W-1:0] gain;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      foreach (DIRECTED_STEPS[i]) begin
         send_request(DIRECTED_STEPS[i].op, DIRECTED_STEPS[i].col, DIRECTED_STEPS[i].row,
                      DIRECTED_STEPS[i].height, DIRECTED_STEPS[i].fixed,
                      DIRECTED_STEPS[i].want);
      end
      drain_block();

      // Six phases: gain extremes, random gains and the reset gain, idling pattern by pairs.
      for (int phase = 0; phase < 6; phase++) begin
         case (phase / 2)
            0: begin
               req_idle_pct = 27;
               rsp_idle_pct = 63;
            end
            1: begin
               req_idle_pct = 63;
               rsp_idle_pct = 27;
            end
            default: begin
               req_idle_pct = 0;
               rsp_idle_pct = 0;
            end
         endcase
         case (phase)
            0: gain = '0;
            1: gain = '1;
            3: gain = 16'd1;
            5: gain = GAIN_RESET;
            default: gain = $urandom();
         endcase
         write_gain(gain);
         run_random(PHASE_ITEMS);
         drain_block();
      end

      if (mismatch_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
